FILE: rtl/rtcm_pkg.sv
// Package for the RTCM3 deframer: phase codes, result record and the CRC-24Q byte update.
// It depends on nothing else. Every other file in rtl/ imports it.
package rtcm_pkg;

	localparam logic [7:0]  PREAMBLE_BYTE = 8'hD3;
	localparam logic [7:0]  PAD_MASK      = 8'hFC;
	localparam logic [24:0] CRC24Q_POLY   = 25'h1864CFB;

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_HDR2    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CRC     = 5'b10000
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        last;
		logic        crc_ok;
		logic [11:0] msg_type;
		logic [9:0]  frame_length;
	} result_t;

	function automatic logic [23:0] crc24q_feed(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		logic [24:0] t;
		c = crc ^ {b, 16'h0000};
		for (int k = 0; k < 8; k++) begin
			t = {c, 1'b0};
			if (t[24]) begin
				t = t ^ CRC24Q_POLY;
			end
			c = t[23:0];
		end
		return c;
	endfunction

endpackage

FILE: rtl/rtcm_in_stage.sv
// Input register of the RTCM3 deframer: holds one received byte until the frame logic takes it.
// It imports rtcm_pkg but uses nothing from it.
module rtcm_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import rtcm_pkg::*;

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

FILE: rtl/rtcm_frame_fsm.sv
// Frame state machine of the RTCM3 deframer: preamble hunt, header, payload and CRC-24Q check.
// It depends on rtcm_pkg for the phase codes, the result record and the CRC update.
module rtcm_frame_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_s1,
	output logic              has_result,
	output rtcm_pkg::result_t result
);
	import rtcm_pkg::*;

	phase_t      phase_q, phase_d;
	logic [23:0] crc_q, crc_d, crc_next, crc_start;
	logic [9:0]  len_q, len_d;
	logic [9:0]  count_q, count_d, count_inc;
	logic [1:0]  seen_q, seen_d, seen_inc;
	logic [11:0] type_q, type_d;

	assign crc_next  = crc24q_feed(crc_q, byte_s1);
	assign crc_start = crc24q_feed(24'h000000, byte_s1);
	assign count_inc = count_q + 10'd1;
	assign seen_inc  = seen_q + 2'd1;

	always_comb begin
		phase_d    = phase_q;
		crc_d      = crc_q;
		len_d      = len_q;
		count_d    = count_q;
		seen_d     = seen_q;
		type_d     = type_q;
		has_result = 1'b0;
		result     = '0;
		unique case (phase_q)
			PH_HDR1: begin
				if ((byte_s1 & PAD_MASK) != 8'h00) begin
					if (byte_s1 == PREAMBLE_BYTE) begin
						crc_d   = crc_start;
						len_d   = '0;
						count_d = '0;
						seen_d  = '0;
						type_d  = '0;
						phase_d = PH_HDR1;
					end else begin
						phase_d = PH_HUNT;
					end
				end else begin
					crc_d   = crc_next;
					len_d   = {byte_s1[1:0], 8'h00};
					phase_d = PH_HDR2;
				end
			end
			PH_HDR2: begin
				crc_d   = crc_next;
				len_d   = {len_q[9:8], byte_s1};
				count_d = '0;
				phase_d = ({len_q[9:8], byte_s1} == 10'd0) ? PH_CRC : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d = crc_next;
				if (count_q == 10'd0) begin
					type_d = {byte_s1, 4'h0};
				end else if (count_q == 10'd1) begin
					type_d = {type_q[11:4], type_q[3:0] | byte_s1[7:4]};
				end
				count_d = count_inc;
				if (count_inc >= len_q) begin
					phase_d = PH_CRC;
				end
				has_result  = 1'b1;
				result.data = byte_s1;
			end
			PH_CRC: begin
				crc_d  = crc_next;
				seen_d = seen_inc;
				if (seen_inc == 2'd3) begin
					has_result          = 1'b1;
					result.kind         = 1'b1;
					result.last         = 1'b1;
					result.crc_ok       = (crc_next == 24'h000000);
					result.msg_type     = (len_q >= 10'd2) ? type_q : 12'h000;
					result.frame_length = len_q;
					seen_d              = '0;
					count_d             = '0;
					phase_d             = PH_HUNT;
				end
			end
			default: begin
				if (byte_s1 == PREAMBLE_BYTE) begin
					crc_d   = crc_start;
					len_d   = '0;
					count_d = '0;
					seen_d  = '0;
					type_d  = '0;
					phase_d = PH_HDR1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= '0;
			len_q   <= '0;
			count_q <= '0;
			seen_q  <= '0;
			type_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			len_q   <= len_d;
			count_q <= count_d;
			seen_q  <= seen_d;
			type_q  <= type_d;
		end
	end

endmodule

FILE: rtl/rtcm3_frame_deframer_crc24q_unit.sv
// Top level of the RTCM3 deframer with CRC-24Q check: input register, frame logic, result register.
// It depends on rtcm_pkg, rtcm_in_stage and rtcm_frame_fsm.
//
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per transaction.
// The output channel (out_valid, out_ready and the result fields) gives one transaction
// per payload byte (kind 0) and one status transaction per frame (kind 1, last 1) that
// carries crc_ok, msg_type and frame_length after the third CRC byte.
// A byte passes through an input register and the frame logic into a result register,
// from which its result is offered once the frame logic has taken the byte.
// The block takes one byte per cycle while the receiver keeps out_ready high; the
// byte-wide CRC-24Q update is the longest path between the two registers.
// When the receiver stalls, the result register holds its transaction, one more byte
// waits in the input register, and in_ready then falls until the result is taken.
// A byte that causes no result leaves the input register at the next edge as well,
// unless a stalled result holds it there.
// Reset clears both valid flags and returns the frame logic to preamble hunting.
module rtcm3_frame_deframer_crc24q_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  data,
	output logic        last,
	output logic        crc_ok,
	output logic [11:0] msg_type,
	output logic [9:0]  frame_length
);
	import rtcm_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       has_result;
	result_t    result;
	result_t    result_q;
	logic       out_valid_q;

	assign adv = valid_s1 && (!out_valid_q || out_ready);

	rtcm_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rtcm_frame_fsm u_frame_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.byte_s1    (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = result_q.kind;
	assign data         = result_q.data;
	assign last         = result_q.last;
	assign crc_ok       = result_q.crc_ok;
	assign msg_type     = result_q.msg_type;
	assign frame_length = result_q.frame_length;

endmodule
